### rtl/core/knot_table_linear_interpolator_macros.svh
// ----------------------------------------------------------------------------
// knot table interpolator assertion macros
// shared concurrent assertion forms, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef KNOT_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define KNOT_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define KTLI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KTLI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ktli_pkg.sv
// ----------------------------------------------------------------------------
// ktli_pkg
// shared sizes, codes and types of the knot table interpolator
// ----------------------------------------------------------------------------
package ktli_pkg;

    localparam int MAX_KNOTS   = 64;
    localparam int VECTOR_DIM  = 4;

    localparam int DATA_W      = 32;
    localparam int TIME_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int STORE_DEPTH = MAX_KNOTS * VECTOR_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SEG_W       = $clog2(MAX_KNOTS);
    localparam int QUO_W       = SEG_W + FRAC_W;
    localparam int NUM_W       = TIME_W + SEG_W;
    localparam int ELEM_W      = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
    localparam int KCMP_W      = (SEG_W + 1 > 7) ? SEG_W + 1 : 7;
    localparam int CFG_IDX_W   = 2;

    localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MODE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_MULT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/core/ktli_ram.sv
// ----------------------------------------------------------------------------
// ktli_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module ktli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

### rtl/core/ktli_div.sv
// ----------------------------------------------------------------------------
// ktli_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ktli_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ktli_pkg::NUM_W-1:0]   numer,
    input  logic [ktli_pkg::TIME_W-1:0]  denom,
    output logic [ktli_pkg::QUO_W-1:0]   quotient,
    output ktli_pkg::div_stat_t          stat
);

    localparam int CNT_W = $clog2(ktli_pkg::QUO_W + 1);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [ktli_pkg::TIME_W-1:0]  rem_reg, rem_next;
    logic [ktli_pkg::QUO_W-1:0]   sh_reg, sh_next;
    logic [ktli_pkg::TIME_W-1:0]  den_reg, den_next;
    logic [ktli_pkg::TIME_W:0]    trial;
    logic                         qbit;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        trial     = {rem_reg, sh_reg[ktli_pkg::QUO_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        if (start) begin
            // numerator shifted up by the fraction bits; the top part is below denom
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ktli_pkg::QUO_W);
            rem_next  = numer[ktli_pkg::NUM_W-1:ktli_pkg::SEG_W];
            sh_next   = {numer[ktli_pkg::SEG_W-1:0], {ktli_pkg::FRAC_W{1'b0}}};
            den_next  = denom;
        end else if (busy_reg) begin
            rem_next = qbit ? ktli_pkg::TIME_W'(trial - {1'b0, den_reg})
                            : ktli_pkg::TIME_W'(trial);
            sh_next  = {sh_reg[ktli_pkg::QUO_W-2:0], qbit};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign quotient  = sh_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### rtl/core/ktli_blend.sv
// ----------------------------------------------------------------------------
// ktli_blend
// linear blend of two knot samples, registered product, rounded result
// ----------------------------------------------------------------------------
module ktli_blend (
    input  logic                               aclk,
    input  logic                               load,
    input  logic signed [ktli_pkg::DATA_W-1:0] u0,
    input  logic signed [ktli_pkg::DATA_W-1:0] u1,
    input  logic        [ktli_pkg::FRAC_W:0]   frac,
    output logic signed [ktli_pkg::DATA_W-1:0] value
);

    localparam int DIFF_W = ktli_pkg::DATA_W + 1;
    localparam int PROD_W = DIFF_W + ktli_pkg::FRAC_W + 2;
    localparam int ACC_W  = PROD_W + 1;

    logic signed [DIFF_W-1:0]          diff;
    logic signed [PROD_W-1:0]          prod_reg;
    logic signed [ktli_pkg::DATA_W-1:0] u0_reg;
    logic signed [ACC_W-1:0]           acc;

    assign diff = DIFF_W'(u1) - DIFF_W'(u0);

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));
            u0_reg   <= u0;
        end
    end

    // u0 * 2^16 + diff * frac + half, then arithmetic floor
    always_comb begin
        acc   = (ACC_W'(u0_reg) <<< ktli_pkg::FRAC_W) + ACC_W'(prod_reg)
              + ACC_W'(1 <<< (ktli_pkg::FRAC_W - 1));
        value = acc[ktli_pkg::FRAC_W +: ktli_pkg::DATA_W];
    end

endmodule

### rtl/core/knot_table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// knot_table_linear_interpolator
// knot table with first-order-hold or zero-order-hold time interpolation
// ----------------------------------------------------------------------------
// usage:
//   input channel s_*: a write transaction (opcode 0) stores one element of one
//   knot and yields no result; out-of-range knot or element indexes are dropped.
//   a query transaction (opcode 1) gives a time and yields VECTOR_DIM result
//   transactions on m_*, elements 0 upward, m_last_element on the final one.
//   writes are taken one per cycle; a query holds s_ready low until its last
//   element has been loaded into the output register.
//   course of a query: the divider works out the segment position (QUO_W = 22
//   quotient bits with 64 knots), skipped at or past the end of the span;
//   then for each element: table read, registered blend product, output
//   load. the last element becomes valid in the same cycle as the block
//   returns to idle, and the next transaction can be accepted in that cycle.
//   a stalled receiver holds the output register and the element sequencer
//   waits on it; the next transaction is accepted while the last element still
//   waits to be taken.
//   configuration: cfg_we with cfg_index and cfg_data, only while idle.
//   reset sets the span to 1.0, knot_count to 2 and first-order mode and
//   empties the pipeline; the knot table is not cleared and holds no meaning
//   until written.
// ----------------------------------------------------------------------------
`include "knot_table_linear_interpolator_macros.svh"

module knot_table_linear_interpolator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_we,
    input  logic [ktli_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ktli_pkg::DATA_W-1:0]           cfg_data,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_opcode,
    input  logic [5:0]                            s_knot_index,
    input  logic [2:0]                            s_element_index,
    input  logic signed [ktli_pkg::DATA_W-1:0]    s_sample_value,
    input  logic [ktli_pkg::TIME_W-1:0]           s_query_time,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [2:0]                            m_out_element,
    output logic signed [ktli_pkg::DATA_W-1:0]    m_out_value,
    output logic                                  m_last_element
);

    localparam logic [ktli_pkg::ADDR_W-1:0] VD_A = ktli_pkg::ADDR_W'(ktli_pkg::VECTOR_DIM);
    localparam logic [ktli_pkg::ELEM_W-1:0] LAST_ELEM =
        ktli_pkg::ELEM_W'(ktli_pkg::VECTOR_DIM - 1);

    // configuration registers
    logic [ktli_pkg::TIME_W-1:0]  span_time_reg;
    logic [6:0]                   knot_count_reg;
    logic                         hold_mode_reg;

    // sequencer
    ktli_pkg::state_t             state_reg, state_next;
    logic [ktli_pkg::SEG_W-1:0]   seg_reg, seg_next;
    logic [ktli_pkg::FRAC_W:0]    frac_reg, frac_next;
    logic [ktli_pkg::ELEM_W-1:0]  elem_reg, elem_next;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic [2:0]                   m_elem_reg, m_elem_next;
    logic signed [ktli_pkg::DATA_W-1:0] m_value_reg, m_value_next;
    logic                         m_last_reg, m_last_next;

    logic                         s_accept;
    logic                         query_accept;
    logic                         past_end;
    logic [ktli_pkg::KCMP_W-1:0]  kc_w;
    logic [ktli_pkg::SEG_W-1:0]   km1;
    logic [ktli_pkg::SEG_W-1:0]   seg_last;
    logic                         slot_free;

    // divider
    logic                         div_start;
    logic [ktli_pkg::NUM_W-1:0]   div_numer;
    logic [ktli_pkg::QUO_W-1:0]   div_quo;
    ktli_pkg::div_stat_t          div_stat;

    // table
    logic                         ram_we;
    logic [ktli_pkg::ADDR_W-1:0]  ram_waddr;
    logic [ktli_pkg::ADDR_W-1:0]  ram_raddr0;
    logic [ktli_pkg::ADDR_W-1:0]  ram_raddr1;
    logic [ktli_pkg::DATA_W-1:0]  ram_rdata0;
    logic [ktli_pkg::DATA_W-1:0]  ram_rdata1;

    logic                         blend_load;
    logic signed [ktli_pkg::DATA_W-1:0] blend_value;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_time_reg  <= ktli_pkg::TIME_W'(65536);
            knot_count_reg <= 7'd2;
            hold_mode_reg  <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ktli_pkg::CFG_TOTAL_TIME: span_time_reg  <= cfg_data;
                ktli_pkg::CFG_KNOT_COUNT: knot_count_reg <= cfg_data[6:0];
                ktli_pkg::CFG_HOLD_MODE:  hold_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // knot count clamped to 2..MAX_KNOTS, kept as k-1
    always_comb begin
        kc_w = ktli_pkg::KCMP_W'(knot_count_reg);
        if (kc_w < ktli_pkg::KCMP_W'(2)) begin
            km1 = ktli_pkg::SEG_W'(1);
        end else if (kc_w > ktli_pkg::KCMP_W'(ktli_pkg::MAX_KNOTS)) begin
            km1 = ktli_pkg::SEG_W'(ktli_pkg::MAX_KNOTS - 1);
        end else begin
            km1 = ktli_pkg::SEG_W'(kc_w - ktli_pkg::KCMP_W'(1));
        end
        seg_last = km1 - ktli_pkg::SEG_W'(1);
    end

    assign s_ready      = (state_reg == ktli_pkg::S_IDLE);
    assign s_accept     = s_valid && s_ready;
    assign query_accept = s_accept && (s_opcode == ktli_pkg::OP_QUERY);
    // zero span also lands here
    assign past_end     = (s_query_time >= span_time_reg);

    // table writes go straight in on acceptance
    assign ram_we = s_accept && (s_opcode == ktli_pkg::OP_WRITE)
                 && (32'(s_knot_index) < 32'(ktli_pkg::MAX_KNOTS))
                 && (32'(s_element_index) < 32'(ktli_pkg::VECTOR_DIM));
    assign ram_waddr = ktli_pkg::ADDR_W'(s_knot_index) * VD_A
                     + ktli_pkg::ADDR_W'(s_element_index);

    // paired read: lower knot and the knot after it
    assign ram_raddr0 = ktli_pkg::ADDR_W'(seg_reg) * VD_A + ktli_pkg::ADDR_W'(elem_reg);
    assign ram_raddr1 = ram_raddr0 + VD_A;

    // time * (k-1), the divider registers it
    assign div_numer = ktli_pkg::NUM_W'(s_query_time) * ktli_pkg::NUM_W'(km1);
    assign div_start = query_accept && !past_end;

    assign slot_free  = !m_valid_reg || m_ready;
    assign blend_load = (state_reg == ktli_pkg::S_MULT);

    always_comb begin
        state_next   = state_reg;
        seg_next     = seg_reg;
        frac_next    = frac_reg;
        elem_next    = elem_reg;
        m_valid_next = m_valid_reg;
        m_elem_next  = m_elem_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ktli_pkg::S_IDLE: begin
                if (query_accept) begin
                    elem_next = '0;
                    if (past_end) begin
                        // last segment; fraction saturated to one, or zero in zero-order mode
                        seg_next   = seg_last;
                        frac_next  = hold_mode_reg ? ktli_pkg::FRAC_ONE : '0;
                        state_next = ktli_pkg::S_READ;
                    end else begin
                        state_next = ktli_pkg::S_DIV;
                    end
                end
            end
            ktli_pkg::S_DIV: begin
                if (div_stat.done) begin
                    // quotient below (k-1)<<16, so the segment needs no clamp
                    seg_next   = div_quo[ktli_pkg::QUO_W-1:ktli_pkg::FRAC_W];
                    frac_next  = hold_mode_reg ? {1'b0, div_quo[ktli_pkg::FRAC_W-1:0]} : '0;
                    state_next = ktli_pkg::S_READ;
                end
            end
            ktli_pkg::S_READ: begin
                state_next = ktli_pkg::S_MULT;
            end
            ktli_pkg::S_MULT: begin
                state_next = ktli_pkg::S_OUT;
            end
            ktli_pkg::S_OUT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_elem_next  = 3'(elem_reg);
                    m_value_next = blend_value;
                    m_last_next  = (elem_reg == LAST_ELEM);
                    if (elem_reg == LAST_ELEM) begin
                        state_next = ktli_pkg::S_IDLE;
                    end else begin
                        elem_next  = elem_reg + ktli_pkg::ELEM_W'(1);
                        state_next = ktli_pkg::S_READ;
                    end
                end
            end
            default: state_next = ktli_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ktli_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        seg_reg     <= seg_next;
        frac_reg    <= frac_next;
        elem_reg    <= elem_next;
        m_elem_reg  <= m_elem_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_element  = m_elem_reg;
    assign m_out_value    = m_value_reg;
    assign m_last_element = m_last_reg;

    ktli_ram #(
        .WIDTH (ktli_pkg::DATA_W),
        .DEPTH (ktli_pkg::STORE_DEPTH)
    ) u_knot_store (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (s_sample_value),
        .raddr0 (ram_raddr0),
        .raddr1 (ram_raddr1),
        .rdata0 (ram_rdata0),
        .rdata1 (ram_rdata1)
    );

    ktli_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (span_time_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // in zero-order mode the upper knot may never have been written,
    // so the lower knot stands in for it
    ktli_blend u_blend (
        .aclk  (aclk),
        .load  (blend_load),
        .u0    ($signed(ram_rdata0)),
        .u1    (hold_mode_reg ? $signed(ram_rdata1) : $signed(ram_rdata0)),
        .frac  (frac_reg),
        .value (blend_value)
    );

    // divider activity only while the sequencer waits on it
    `KTLI_ASSERT_IMP(a_div_in_div_state, div_stat.busy || div_stat.done, state_reg == ktli_pkg::S_DIV, "divider active outside the division state")
    // table writes never overlap a query's reads
    `KTLI_ASSERT_IMP(a_write_only_idle, ram_we, state_reg == ktli_pkg::S_IDLE, "table write while a query is in flight")
    // segment and fraction stay within the table
    `KTLI_ASSERT_IMP(a_seg_bound, state_reg == ktli_pkg::S_READ, (seg_reg <= seg_last) && (frac_reg <= ktli_pkg::FRAC_ONE), "segment or fraction out of range")
    // the last element closes the query
    `KTLI_ASSERT_NXT(a_last_to_idle, (state_reg == ktli_pkg::S_OUT) && slot_free && (elem_reg == LAST_ELEM), (state_reg == ktli_pkg::S_IDLE) && m_valid_reg && m_last_reg, "last element did not end the query")

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the knot table interpolator: random knot writes and
// queries against a cycle-free predictor, with random idling on both channels
// ----------------------------------------------------------------------------
module tb;

    // spare register index, the block must ignore it
    localparam logic [ktli_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // cycles to let a trailing write or query settle before touching registers
    localparam int SETTLE_CYCLES = 48;
    // receiver hold-off used to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 400;
    // meaningful transactions per random phase
    localparam int PHASE_ITEMS = 37;

    typedef struct {
        logic                          opcode;
        logic [5:0]                    knot;
        logic [2:0]                    elem;
        logic [ktli_pkg::DATA_W-1:0]   sample;
        logic [ktli_pkg::TIME_W-1:0]   qtime;
    } knot_op_t;

    typedef struct {
        logic [2:0]                    elem;
        logic [ktli_pkg::DATA_W-1:0]   value;
        logic                          last;
    } vec_result_t;

    logic                               aclk            = 1'b0;
    logic                               aresetn         = 1'b0;
    logic                               cfg_we          = 1'b0;
    logic [ktli_pkg::CFG_IDX_W-1:0]     cfg_index       = '0;
    logic [ktli_pkg::DATA_W-1:0]        cfg_data        = '0;
    logic                               s_valid         = 1'b0;
    logic                               s_ready;
    logic                               s_opcode        = ktli_pkg::OP_WRITE;
    logic [5:0]                         s_knot_index    = '0;
    logic [2:0]                         s_element_index = '0;
    logic signed [ktli_pkg::DATA_W-1:0] s_sample_value  = '0;
    logic [ktli_pkg::TIME_W-1:0]        s_query_time    = '0;
    logic                               m_valid;
    logic                               m_ready         = 1'b0;
    logic [2:0]                         m_out_element;
    logic signed [ktli_pkg::DATA_W-1:0] m_out_value;
    logic                               m_last_element;

    knot_table_linear_interpolator u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_knot_index    (s_knot_index),
        .s_element_index (s_element_index),
        .s_sample_value  (s_sample_value),
        .s_query_time    (s_query_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_element   (m_out_element),
        .m_out_value     (m_out_value),
        .m_last_element  (m_last_element)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow registers, knot mirror and queues
    // ------------------------------------------------------------------
    logic [ktli_pkg::TIME_W-1:0]  span_reg   = 32'd65536;    // span of the sequence
    logic [6:0]                   knots_reg  = 7'd2;         // knot_count
    logic                         blend_on   = 1'b1;         // hold_mode

    // mirror of the table as the block sees it, updated on accepted writes
    logic [ktli_pkg::DATA_W-1:0]  knot_mirror  [ktli_pkg::STORE_DEPTH];
    // entries that some queued write will have filled, tracked at generation
    bit                           knot_planned [ktli_pkg::STORE_DEPTH];

    knot_op_t           pending_ops[$];
    vec_result_t        vector_expect[$];

    int                 useful_items = 0;
    int                 error_count  = 0;

    // idling controls, owned by the main sequence
    bit                 tx_calm = 1'b0;
    bit                 rx_calm = 1'b0;
    int                 hold_off_requests = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // knot count as the block uses it: clamped into 2..MAX_KNOTS
    function automatic int active_knots();
        if (knots_reg < 2)
            return 2;
        if (knots_reg > ktli_pkg::MAX_KNOTS)
            return ktli_pkg::MAX_KNOTS;
        return int'(knots_reg);
    endfunction

    // segment number and 17-bit fraction (1.0 when saturated) for a query time
    function automatic void locate_segment(input logic [ktli_pkg::TIME_W-1:0] qt,
                                           output int seg, output int frac);
        int          k;
        logic [63:0] pos;
        k = active_knots();
        if (span_reg == 0 || qt >= span_reg) begin
            // at or past the end: last segment, fraction pinned to one
            seg  = k - 2;
            frac = int'(ktli_pkg::FRAC_ONE);
        end else begin
            pos  = ((64'(qt) * 64'(k - 1)) << ktli_pkg::FRAC_W) / 64'(span_reg);
            seg  = int'(pos >> ktli_pkg::FRAC_W);
            frac = int'(pos[ktli_pkg::FRAC_W-1:0]);
            if (seg > k - 2) begin
                seg  = k - 2;
                frac = int'(ktli_pkg::FRAC_ONE);
            end
        end
    endfunction

    // u0 + (u1-u0)*frac, rounded to nearest with ties going up
    function automatic logic [ktli_pkg::DATA_W-1:0] blend_fixed(
            input logic signed [ktli_pkg::DATA_W-1:0] lo,
            input logic signed [ktli_pkg::DATA_W-1:0] hi,
            input int frac);
        longint acc;
        acc = longint'(lo) * 65536 + (longint'(hi) - longint'(lo)) * longint'(frac) + 32768;
        return ktli_pkg::DATA_W'(acc >>> ktli_pkg::FRAC_W);
    endfunction

    task automatic predict_vector(input logic [ktli_pkg::TIME_W-1:0] qt);
        int          seg;
        int          frac;
        int          e;
        vec_result_t r;
        locate_segment(qt, seg, frac);
        for (e = 0; e < ktli_pkg::VECTOR_DIM; e++) begin
            r.elem = 3'(e);
            if (blend_on)
                r.value = blend_fixed(knot_mirror[seg * ktli_pkg::VECTOR_DIM + e],
                                      knot_mirror[(seg + 1) * ktli_pkg::VECTOR_DIM + e],
                                      frac);
            else
                r.value = knot_mirror[seg * ktli_pkg::VECTOR_DIM + e];
            r.last = (e == ktli_pkg::VECTOR_DIM - 1);
            vector_expect.insert(vector_expect.size(), r);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    task automatic push_op(input logic opcode, input logic [5:0] knot, input logic [2:0] elem,
                           input logic [ktli_pkg::DATA_W-1:0] sample,
                           input logic [ktli_pkg::TIME_W-1:0] qtime);
        knot_op_t op;
        op.opcode = opcode;
        op.knot   = knot;
        op.elem   = elem;
        op.sample = sample;
        op.qtime  = qtime;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    task automatic queue_write(input int knot, input int elem,
                               input logic [ktli_pkg::DATA_W-1:0] value);
        // element indexes past the vector are dropped by the block
        if (elem < ktli_pkg::VECTOR_DIM) begin
            knot_planned[knot * ktli_pkg::VECTOR_DIM + elem] = 1'b1;
            useful_items++;
        end
        push_op(ktli_pkg::OP_WRITE, 6'(knot), 3'(elem), value, $urandom());
    endtask

    // fill both neighbouring knots first so no query reads an unwritten entry
    task automatic queue_query(input logic [ktli_pkg::TIME_W-1:0] qt);
        int seg;
        int frac;
        int kn;
        int e;
        locate_segment(qt, seg, frac);
        for (kn = seg; kn <= seg + 1; kn++)
            for (e = 0; e < ktli_pkg::VECTOR_DIM; e++)
                if (!knot_planned[kn * ktli_pkg::VECTOR_DIM + e])
                    queue_write(kn, e, $urandom());
        useful_items++;
        push_op(ktli_pkg::OP_QUERY, 6'($urandom()), 3'($urandom()), $urandom(), qt);
    endtask

    function automatic logic [ktli_pkg::DATA_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // query times clustered around the interesting spots of the span
    function automatic logic [ktli_pkg::TIME_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return span_reg - ktli_pkg::TIME_W'($urandom_range(0, 1));
            2:       return $urandom();
            3:       return span_reg + ktli_pkg::TIME_W'($urandom_range(0, 1000));
            4:       return 32'hFFFF_FFFF;
            default: return (span_reg == 0) ? $urandom() : $urandom_range(0, span_reg - 1);
        endcase
    endfunction

    task automatic random_phase();
        int goal;
        int knot;
        goal = useful_items + PHASE_ITEMS;
        while (useful_items < goal) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                    queue_query(pick_time());
                end
                17, 18, 19: begin
                    // dropped write: element past the vector
                    queue_write($urandom_range(0, ktli_pkg::MAX_KNOTS - 1),
                                $urandom_range(ktli_pkg::VECTOR_DIM, 7), $urandom());
                end
                default: begin
                    knot = ($urandom_range(0, 3) == 0)
                         ? $urandom_range(0, ktli_pkg::MAX_KNOTS - 1)
                         : $urandom_range(0, active_knots() - 1);
                    queue_write(knot, $urandom_range(0, ktli_pkg::VECTOR_DIM - 1),
                                pick_sample());
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // register writes, only while the block is idle
    // ------------------------------------------------------------------

    // leaves cfg_we high so back-to-back writes need no gap
    task automatic write_reg(input logic [ktli_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ktli_pkg::DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            ktli_pkg::CFG_TOTAL_TIME: span_reg  = data;
            ktli_pkg::CFG_KNOT_COUNT: knots_reg = data[6:0];
            ktli_pkg::CFG_HOLD_MODE:  blend_on  = data[0];
            default: ;
        endcase
    endtask

    // upper data bits are junk on the narrow registers, the block must drop them
    task automatic apply_setting(input logic [ktli_pkg::TIME_W-1:0] span, input int knots,
                                 input bit mode);
        write_reg(ktli_pkg::CFG_TOTAL_TIME, span);
        write_reg(ktli_pkg::CFG_KNOT_COUNT, ($urandom() & ~32'h7F) | 32'(knots));
        write_reg(ktli_pkg::CFG_HOLD_MODE, ($urandom() & ~32'h1) | 32'(mode));
        @(negedge aclk);
        cfg_we <= 1'b0;
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
    endtask

    // everything offered, accepted and answered, then let the pipeline go quiet;
    // checked at the rising edge, where the driver never changes anything
    task automatic wait_idle();
        while (pending_ops.size() != 0 || s_valid || vector_expect.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // input driver: valid held with a stable payload until the transaction
    // ------------------------------------------------------------------
    bit       tx_taken;
    int       tx_gap = 0;
    knot_op_t tx_op;

    always begin
        @(posedge aclk);
        tx_taken = s_valid && s_ready;
        @(negedge aclk);
        if (tx_taken || !s_valid) begin
            if (tx_taken && !tx_calm) begin
                case ($urandom_range(0, 99)) inside
                    [0:69]:  tx_gap = 0;
                    [70:95]: tx_gap = $urandom_range(1, 3);
                    default: tx_gap = $urandom_range(15, 50);
                endcase
            end
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
                tx_op = pending_ops.pop_front();
                s_valid         <= 1'b1;
                s_opcode        <= tx_op.opcode;
                s_knot_index    <= tx_op.knot;
                s_element_index <= tx_op.elem;
                s_sample_value  <= tx_op.sample;
                s_query_time    <= tx_op.qtime;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random pauses, plus a long hold-off on request
    // ------------------------------------------------------------------
    int hold_off_served = 0;
    int hold_off_left   = 0;
    int rx_pause        = 0;

    // hold-off counter in its own process so it runs regardless of traffic
    always @(negedge aclk) begin
        if (hold_off_served != hold_off_requests) begin
            hold_off_served <= hold_off_requests;
            hold_off_left   <= HOLD_OFF_CYCLES;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn || hold_off_left != 0) begin
            m_ready <= 1'b0;
        end else if (rx_pause != 0) begin
            rx_pause--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!rx_calm) begin
                case ($urandom_range(0, 99)) inside
                    [0:74]:  rx_pause = 0;
                    [75:95]: rx_pause = $urandom_range(1, 3);
                    default: rx_pause = $urandom_range(10, 30);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on accepted inputs, check accepted results in order
    // ------------------------------------------------------------------
    vec_result_t got_ref;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (s_opcode == ktli_pkg::OP_QUERY)
                    predict_vector(s_query_time);
                else if (s_element_index < ktli_pkg::VECTOR_DIM)
                    knot_mirror[int'(s_knot_index) * ktli_pkg::VECTOR_DIM
                                + int'(s_element_index)] = s_sample_value;
            end
            if (m_valid && m_ready) begin
                if (vector_expect.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result transaction: element %0d value %h last %0d",
                                 m_out_element, m_out_value, m_last_element);
                end else begin
                    got_ref = vector_expect.pop_front();
                    if (m_out_element !== got_ref.elem || m_out_value !== got_ref.value ||
                        m_last_element !== got_ref.last) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch exp/got: elem %0d/%0d value %h/%h last %0d/%0d",
                                     got_ref.elem, m_out_element, got_ref.value, m_out_value,
                                     got_ref.last, m_last_element);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part on reset settings: one segment over one second, blend on
        // opposite extremes on the first two elements, sign crossing on the third
        queue_write(0, 0, 32'h8000_0000);
        queue_write(1, 0, 32'h7FFF_FFFF);
        queue_write(0, 1, 32'h7FFF_FFFF);
        queue_write(1, 1, 32'h8000_0000);
        queue_write(0, 2, 32'h0000_0000);
        queue_write(1, 2, 32'hFFFF_FFFF);
        queue_write(0, 3, 32'h0001_0000);
        queue_write(1, 3, 32'h0002_0000);
        // highest knot, and writes past the vector that must not alias
        queue_write(63, 0, 32'h1234_5678);
        queue_write(0, 4, 32'hDEAD_BEEF);
        queue_write(5, 7, 32'hCAFE_F00D);
        // start, exact half, largest fraction, at the end, far past it
        queue_query(32'h0000_0000);
        queue_query(32'h0000_8000);
        queue_query(32'h0000_FFFF);
        queue_query(32'h0001_0000);
        queue_query(32'hFFFF_FFFF);
        wait_idle();

        // spare index once, then settings from the extremes inward
        write_reg(CFG_SPARE, $urandom());
        apply_setting(32'hFFFF_FFFF, ktli_pkg::MAX_KNOTS, 1'b1);
        random_phase();
        wait_idle();

        apply_setting(32'd1, 2, 1'b0);
        random_phase();
        wait_idle();

        // zero span: every query lands past the end
        apply_setting(32'd0, 17, 1'b1);
        random_phase();
        wait_idle();

        // knot counts outside the table: zero and one act as two
        apply_setting($urandom(), 1, 1'b1);
        random_phase();
        wait_idle();

        apply_setting($urandom_range(1, 32'h00FF_FFFF), 0, 1'b0);
        random_phase();
        wait_idle();

        // too many knots acts as the full table
        apply_setting($urandom(), 127, 1'b0);
        random_phase();
        wait_idle();

        // receiver holds off while the sender keeps offering, block backs up
        apply_setting(32'd10 << 16, 9, 1'b1);
        hold_off_requests++;
        random_phase();
        wait_idle();

        apply_setting($urandom_range(1, 32'h0100_0000), ktli_pkg::MAX_KNOTS, 1'b0);
        random_phase();
        wait_idle();

        apply_setting($urandom(), $urandom_range(2, ktli_pkg::MAX_KNOTS), 1'b1);
        random_phase();
        wait_idle();

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ktli_pkg.sv
rtl/core/ktli_ram.sv
rtl/core/ktli_div.sv
rtl/core/ktli_blend.sv
rtl/core/knot_table_linear_interpolator.sv
bench/tb.sv
